// ===== rtl/core/index_run_sequence_encoder_assert.svh =====
// Assertion macros for the index run sequence encoder.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef INDEX_RUN_SEQUENCE_ENCODER_ASSERT_SVH
`define INDEX_RUN_SEQUENCE_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IRSE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IRSE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/irse_pkg.sv =====
// Shared constants, types and helper functions of the index run sequence encoder.
// No dependencies; imported by every module of the block.
package irse_pkg;

  localparam int INDEX_BITS   = 16;
  localparam int FILE_INDEX_W = 16;
  localparam int VAL_BITS     = INDEX_BITS + 1;
  localparam int GROUP_BITS   = 3;
  localparam int NUM_GROUPS   = (VAL_BITS + GROUP_BITS - 1) / GROUP_BITS;
  localparam int PAD_BITS     = NUM_GROUPS * GROUP_BITS;
  localparam int GRP_W        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int NUM_SLOTS    = 3;
  localparam int NIBBLE_W     = GROUP_BITS + 1;
  localparam int OUT_DATA_W   = 8;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef logic [VAL_BITS-1:0] val_t;
  typedef logic [GRP_W-1:0]    grp_t;
  typedef logic [1:0]          slot_t;

  localparam slot_t SLOT_LEN   = 2'd0;
  localparam slot_t SLOT_GAP   = 2'd1;
  localparam slot_t SLOT_INDEX = 2'd2;
  localparam slot_t SLOT_PAD   = 2'd3;

  // One queued job: up to three values to send, plus the finish marker.
  typedef struct packed {
    logic                                finish;
    logic [NUM_SLOTS-1:0]                val_ok;
    logic [NUM_SLOTS-1:0][VAL_BITS-1:0]  val;
  } job_t;

  typedef struct packed {
    logic head_valid;
    logic full;
  } q_stat_t;

  // Index of the most significant nonzero 3-bit group; zero for a zero value.
  function automatic grp_t top_group(input val_t v);
    logic [PAD_BITS-1:0] p;
    grp_t                top;
    p   = PAD_BITS'(v);
    top = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (p[g*GROUP_BITS +: GROUP_BITS] != '0) top = GRP_W'(g);
    end
    return top;
  endfunction

  function automatic logic [GROUP_BITS-1:0] group_of(input val_t v, input grp_t g);
    logic [PAD_BITS-1:0] p;
    p = PAD_BITS'(v);
    return p[g*GROUP_BITS +: GROUP_BITS];
  endfunction

endpackage

// ===== rtl/core/irse_front.sv =====
// Front end: accepts index and finish transfers, tracks the open run and
// builds the jobs for the back end. Depends on irse_pkg.
module irse_front import irse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    s_tuser,
  input  logic [FILE_INDEX_W-1:0] s_tdata,
  input  q_stat_t                 q_stat,
  output logic                    push,
  output job_t                    push_job,
  output logic                    run_open
);

  logic [INDEX_BITS-1:0] run_first;
  logic [INDEX_BITS-1:0] run_latest;
  logic [INDEX_BITS-1:0] idx;
  val_t                  idx_ext;
  val_t                  next_pos;
  val_t                  run_len;
  logic                  accept;
  logic                  extend;
  logic                  forward;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign idx      = INDEX_BITS'(s_tdata);
  assign idx_ext  = VAL_BITS'(idx);
  // Position just past the open run; it does not wrap at the top index.
  assign next_pos = run_open ? (VAL_BITS'(run_latest) + VAL_BITS'(1)) : '0;
  assign run_len  = VAL_BITS'(run_latest) - VAL_BITS'(run_first) + VAL_BITS'(1);
  assign extend   = (idx_ext == next_pos);
  assign forward  = run_open && (idx_ext > next_pos);

  always_comb begin
    push_job        = '0;
    push_job.val[0] = run_len;
    push_job.val_ok = {1'b0, 1'b0, run_open};
    if (s_tuser == CMD_FINISH) begin
      push_job.finish = 1'b1;
    end else begin
      push_job.val[1]    = forward ? (idx_ext - next_pos) : '0;
      push_job.val[2]    = idx_ext;
      push_job.val_ok[1] = 1'b1;
      push_job.val_ok[2] = !forward;
    end
  end

  assign push = accept && ((s_tuser == CMD_FINISH) || !extend);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open   <= 1'b0;
      run_first  <= '0;
      run_latest <= '0;
    end else if (accept) begin
      if (s_tuser == CMD_FINISH) begin
        run_open   <= 1'b0;
        run_first  <= '0;
        run_latest <= '0;
      end else begin
        run_open   <= 1'b1;
        run_latest <= idx;
        if (!(extend && run_open)) run_first <= idx;
      end
    end
  end

endmodule

// ===== rtl/core/irse_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on irse_pkg for the job type and depth.
module irse_queue import irse_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head_job,
  output q_stat_t stat
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign head_job        = entries[rd_ptr];
  assign stat.head_valid = (count != '0);
  assign stat.full       = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/irse_back.sv =====
// Back end: walks the slots of the head job and sends each value as 3-bit
// groups, most significant first, then any due padding nibble. Depends on irse_pkg.
module irse_back import irse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  job_t                  head_job,
  input  q_stat_t               q_stat,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  typedef enum logic [1:0] {
    ST_SELECT = 2'b01,
    ST_EMIT   = 2'b10
  } state_t;

  state_t                state;
  state_t                state_next;
  slot_t                 slot;
  slot_t                 slot_next;
  grp_t                  grp;
  grp_t                  grp_next;
  logic                  parity;
  logic                  parity_next;
  logic                  out_valid;
  logic [NIBBLE_W-1:0]   out_nibble;
  logic                  out_last;
  logic                  can_load;
  logic                  load;
  logic [NIBBLE_W-1:0]   load_nibble;
  logic                  load_last;
  val_t                  cur;
  logic                  cur_ok;
  logic                  later_ok;

  assign can_load = !out_valid || m_tready;

  always_comb begin
    case (slot)
      SLOT_LEN: begin
        cur      = head_job.val[0];
        cur_ok   = head_job.val_ok[0];
        later_ok = |head_job.val_ok[2:1];
      end
      SLOT_GAP: begin
        cur      = head_job.val[1];
        cur_ok   = head_job.val_ok[1];
        later_ok = head_job.val_ok[2];
      end
      SLOT_INDEX: begin
        cur      = head_job.val[2];
        cur_ok   = head_job.val_ok[2];
        later_ok = 1'b0;
      end
      default: begin
        cur      = '0;
        cur_ok   = 1'b0;
        later_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next  = state;
    slot_next   = slot;
    grp_next    = grp;
    parity_next = parity;
    pop         = 1'b0;
    load        = 1'b0;
    load_nibble = '0;
    load_last   = 1'b0;
    unique case (state)
      ST_SELECT: begin
        if (q_stat.head_valid) begin
          if (slot != SLOT_PAD) begin
            if (cur_ok) begin
              grp_next   = top_group(cur);
              state_next = ST_EMIT;
            end else begin
              slot_next = slot_t'(slot + 2'd1);
            end
          end else if (head_job.finish && parity) begin
            // Odd nibble count at finish: one zero nibble closes the byte.
            if (can_load) begin
              load        = 1'b1;
              load_last   = 1'b1;
              pop         = 1'b1;
              parity_next = 1'b0;
              slot_next   = SLOT_LEN;
            end
          end else begin
            pop       = 1'b1;
            slot_next = SLOT_LEN;
            if (head_job.finish) parity_next = 1'b0;
          end
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          load        = 1'b1;
          parity_next = ~parity;
          load_nibble = {grp != '0, group_of(cur, grp)};
          if (grp == '0) begin
            // Last group of this value; the job ends here unless another
            // value follows or a padding nibble is still due.
            load_last  = !later_ok && !(head_job.finish && !parity);
            slot_next  = slot_t'(slot + 2'd1);
            state_next = ST_SELECT;
          end else begin
            grp_next = grp - GRP_W'(1);
          end
        end
      end
      default: state_next = ST_SELECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SELECT;
      slot      <= SLOT_LEN;
      grp       <= '0;
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      slot   <= slot_next;
      grp    <= grp_next;
      parity <= parity_next;
      if (load)          out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_nibble <= load_nibble;
      out_last   <= load_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'(out_nibble);
  assign m_tlast  = out_last;

endmodule

// ===== rtl/core/index_run_sequence_encoder.sv =====
// Top level of the index run sequence encoder: front end, job queue, back end.
// Depends on irse_pkg, irse_front, irse_queue, irse_back and the assertion header.
//
//   Channel  Direction  Payload
//   s_*      in         tuser: command; tdata: file_index
//   m_*      out        tdata: nibble; tlast: last_of_run
//
// A transfer that only extends the open run leaves no job behind. Any
// other transfer becomes one job; the back end sends each value nibble
// in its emit state and steps through the job's slots in its select
// state, and the padding nibble, when due, goes out at the last slot step.
// The two-entry job queue lets the front end keep accepting transfers
// while the back end works; s_tready drops only when the queue is full.
// Reset is synchronous and active high and needs no clearing pass.
`include "index_run_sequence_encoder_assert.svh"

module index_run_sequence_encoder import irse_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic                    s_tuser,   // [0] command
  input  logic [FILE_INDEX_W-1:0] s_tdata,   // [15:0] file_index
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_DATA_W-1:0]   m_tdata,   // [3:0] nibble, [7:4] zero
  output logic                    m_tlast
);

  // Jobs travel from the front end through the queue to the back end.
  logic    q_push;
  job_t    q_push_job;
  logic    q_pop;
  job_t    q_head_job;
  q_stat_t q_stat;
  logic    run_open;

  irse_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_job (q_push_job),
    .run_open (run_open)
  );

  irse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head_job),
    .stat     (q_stat)
  );

  // The back end holds the result in an output register, so a stalled
  // sink does not stop the front end from taking further transfers until the job queue is full.
  irse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (q_head_job),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // A finish transfer always leaves the front end with no open run.
  `IRSE_ASSERT_NEXT(a_finish_closes_run, s_tvalid && s_tready && s_tuser == CMD_FINISH, !run_open, "run still open after finish")
  // The back end retires a job only when one is waiting.
  `IRSE_ASSERT_NOW(a_pop_has_head, q_pop, q_stat.head_valid, "job queue popped while empty")
  // The front end never writes into a full queue.
  `IRSE_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "job queue written while full")

endmodule
